// ===== rtl/aff_inv_pkg.sv =====
// Shared widths and cofactor operand tables for the 3x3 adjugate inverse.
// No dependencies.
package aff_inv_pkg;

    localparam int N_ENT   = 9;
    localparam int CW      = 65;
    localparam int DW      = 99;
    localparam int QW      = 32;

    typedef logic signed [31:0]   t_ent;
    typedef logic signed [63:0]   t_prod;
    typedef logic signed [CW-1:0] t_cof;
    typedef logic signed [DW-1:0] t_det;
    typedef logic [DW-1:0]        t_mag;
    typedef logic [3:0]           t_idx;

    // adj[j] = a[A]*a[B] - a[C]*a[D], entries in row-major order
    localparam t_idx IDX_A [N_ENT] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx IDX_B [N_ENT] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx IDX_C [N_ENT] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx IDX_D [N_ENT] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

// ===== rtl/affine_3x3_matrix_inverse.sv =====
// One matrix per cycle; busy stays low.
// Stages: products, cofactors, determinant partial products, terms, sum,
// magnitudes, range check, one quotient bit per stage over 32 stages, then the output register.
// Synchronous active-low reset clears the valid bits; the receiver cannot stall,
// so every beat moves through each stage in order without waiting.
// Depends on aff_inv_pkg.
module affine_3x3_matrix_inverse (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_m00, input logic [31:0] i_m01, input logic [31:0] i_m02,
    input  logic [31:0] i_m10, input logic [31:0] i_m11, input logic [31:0] i_m12,
    input  logic [31:0] i_m20, input logic [31:0] i_m21, input logic [31:0] i_m22,
    output logic        o_done,
    output logic [31:0] o_inv00, output logic [31:0] o_inv01, output logic [31:0] o_inv02,
    output logic [31:0] o_inv10, output logic [31:0] o_inv11, output logic [31:0] o_inv12,
    output logic [31:0] o_inv20, output logic [31:0] o_inv21, output logic [31:0] o_inv22,
    output logic        o_singular,
    output logic        o_saturated
);
    import aff_inv_pkg::*;

    t_ent  a_in [N_ENT];
    logic  v_in;

    // stage 1
    t_prod r_pab [N_ENT];
    t_prod r_pcd [N_ENT];
    t_ent  r_a1  [3];
    logic  r_v1;
    // stage 2
    t_cof  r_cof2 [N_ENT];
    t_ent  r_a2   [3];
    logic  r_v2;
    // stage 3
    t_cof  r_cof3 [N_ENT];
    t_cof  r_lo   [3];
    t_cof  r_hi   [3];
    logic  r_v3;
    // stage 4
    t_cof  r_cof4 [N_ENT];
    t_det  r_term [3];
    logic  r_v4;
    // stage 5
    t_cof  r_cof5 [N_ENT];
    t_det  r_det5;
    logic  r_v5;
    // stage 6
    logic [CW-1:0] r_num6 [N_ENT];
    logic          r_neg6 [N_ENT];
    t_mag          r_den6;
    logic          r_zero6;
    logic          r_v6;
    // division chain, index 0 is the range-check stage
    t_mag          r_rem [QW+1][N_ENT];
    logic [QW-1:0] r_q   [QW+1][N_ENT];
    logic          r_ovf [QW+1][N_ENT];
    logic          r_neg [QW+1][N_ENT];
    t_mag          r_den [QW+1];
    logic          r_zero[QW+1];
    logic          r_v   [QW+1];
    // output
    logic [31:0]   r_out [N_ENT];
    logic          r_sing;
    logic          r_sat;
    logic          r_done;

    assign busy = 1'b0;
    assign v_in = start & ~busy;
    assign a_in[0] = i_m00; assign a_in[1] = i_m01; assign a_in[2] = i_m02;
    assign a_in[3] = i_m10; assign a_in[4] = i_m11; assign a_in[5] = i_m12;
    assign a_in[6] = i_m20; assign a_in[7] = i_m21; assign a_in[8] = i_m22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= v_in;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < N_ENT; j++) begin
            r_pab[j]  <= a_in[IDX_A[j]] * a_in[IDX_B[j]];
            r_pcd[j]  <= a_in[IDX_C[j]] * a_in[IDX_D[j]];
            r_cof2[j] <= CW'(r_pab[j]) - CW'(r_pcd[j]);
            r_cof3[j] <= r_cof2[j];
            r_cof4[j] <= r_cof3[j];
            r_cof5[j] <= r_cof4[j];
            r_num6[j] <= r_cof5[j][CW-1] ? CW'(-r_cof5[j]) : r_cof5[j];
            r_neg6[j] <= r_cof5[j][CW-1] ^ r_det5[DW-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_a1[k]   <= a_in[k];
            r_a2[k]   <= r_a1[k];
            r_lo[k]   <= r_a2[k] * $signed({1'b0, r_cof2[3*k][31:0]});
            r_hi[k]   <= r_a2[k] * $signed(r_cof2[3*k][CW-1:32]);
            r_term[k] <= (DW'(r_hi[k]) <<< 32) + DW'(r_lo[k]);
        end
        r_det5  <= r_term[0] + r_term[1] + r_term[2];
        r_den6  <= r_det5[DW-1] ? t_mag'(-r_det5) : t_mag'(r_det5);
        r_zero6 <= (r_det5 == '0);
    end

    // range check: quotient reaches 2^32 exactly when |num| >= |den|
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_v6;
        end
        for (int j = 0; j < N_ENT; j++) begin
            r_rem[0][j] <= DW'(r_num6[j]);
            r_q[0][j]   <= '0;
            r_ovf[0][j] <= DW'(r_num6[j]) >= r_den6;
            r_neg[0][j] <= r_neg6[j];
        end
        r_den[0]  <= r_den6;
        r_zero[0] <= r_zero6;
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        logic [DW:0] w_sh  [N_ENT];
        logic [DW:0] w_dif [N_ENT];
        always_comb begin
            for (int j = 0; j < N_ENT; j++) begin
                w_sh[j]  = {r_rem[s][j], 1'b0};
                w_dif[j] = w_sh[j] - {1'b0, r_den[s]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
            for (int j = 0; j < N_ENT; j++) begin
                r_rem[s+1][j] <= w_dif[j][DW] ? w_sh[j][DW-1:0] : w_dif[j][DW-1:0];
                r_q[s+1][j]   <= {r_q[s][j][QW-2:0], ~w_dif[j][DW]};
                r_ovf[s+1][j] <= r_ovf[s][j];
                r_neg[s+1][j] <= r_neg[s][j];
            end
            r_den[s+1]  <= r_den[s];
            r_zero[s+1] <= r_zero[s];
        end
    end

    // sign, saturate, drop everything to zero on a singular matrix
    logic [31:0] n_out [N_ENT];
    logic        n_sat;
    always_comb begin
        logic [31:0] q;
        logic        clip;
        n_sat = 1'b0;
        for (int j = 0; j < N_ENT; j++) begin
            q    = r_q[QW][j];
            clip = r_ovf[QW][j] || (r_neg[QW][j] ? (q > SAT_NEG) : (q > SAT_POS));
            if (r_zero[QW]) begin
                n_out[j] = '0;
            end else if (clip) begin
                n_out[j] = r_neg[QW][j] ? SAT_NEG : SAT_POS;
            end else begin
                n_out[j] = r_neg[QW][j] ? -q : q;
            end
            n_sat = n_sat | (clip & ~r_zero[QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v[QW];
        end
        for (int j = 0; j < N_ENT; j++) begin
            r_out[j] <= n_out[j];
        end
        r_sing <= r_zero[QW];
        r_sat  <= n_sat;
    end

    assign o_done      = r_done;
    assign o_inv00     = r_out[0];
    assign o_inv01     = r_out[1];
    assign o_inv02     = r_out[2];
    assign o_inv10     = r_out[3];
    assign o_inv11     = r_out[4];
    assign o_inv12     = r_out[5];
    assign o_inv20     = r_out[6];
    assign o_inv21     = r_out[7];
    assign o_inv22     = r_out[8];
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

endmodule
